// ===== rtl/vtm_pkg.sv =====
package vtm_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF     = 8;
    localparam int TIME_BITS_DEF = 32;

    // At most this many slots fire in one tick
    localparam int MAX_FIRE = 8;

    // Fixed field widths
    localparam int KIND_W = 2;
    localparam int DUR_W  = 32;
    localparam int ID_W   = 3;
    localparam int EV_W   = 2;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result codes
    typedef enum logic [EV_W-1:0] {
        EV_STARTED   = 2'd0,
        EV_FULL      = 2'd1,
        EV_FIRED     = 2'd2,
        EV_CANCELLED = 2'd3
    } event_t;

endpackage

// ===== rtl/virtual_timer_multiplexer_core.sv =====
// Software timer multiplexer: SLOTS timers share one tick counter, advanced by each tick item.
// Pulse start while busy is low to hand in an item (tick, start timer, cancel timer). Each
// result is held for one cycle with result_valid high and must be taken as it appears: the
// block never waits for the receiver. A cancel gives its result on the next cycle and leaves
// busy low. A start walks the armed flags from slot 0 and stays busy until it finds a free
// slot or reports the timers full. A tick runs one search pass over the deadline memory per
// fired slot, plus a closing pass that finds no due slot unless eight slots fired; the single
// read port of the deadline memory makes the passes run one after another. Up to eight slots
// fire per tick, in deadline order, ties to the lower slot; last marks the final result.
module virtual_timer_multiplexer_core #(
    parameter int SLOTS     = vtm_pkg::SLOTS_DEF,
    parameter int TIME_BITS = vtm_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [vtm_pkg::KIND_W-1:0]   kind,
    input  logic [vtm_pkg::DUR_W-1:0]    duration,
    input  logic                         repeat_req,
    input  logic [vtm_pkg::ID_W-1:0]     slot_id,
    output logic                         result_valid,
    output logic [vtm_pkg::EV_W-1:0]     event_res,
    output logic [vtm_pkg::ID_W-1:0]     event_slot,
    output logic                         last
);

    import vtm_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int FIRE_W = $clog2(MAX_FIRE + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FIRE  = 6'b001000,
        S_REARM = 6'b010000,
        S_LAST  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [TIME_BITS-1:0]  pick_dl_reg, pick_dl_next;
    logic                  pick_found_reg, pick_found_next;
    logic [FIRE_W-1:0]     fire_cnt_reg, fire_cnt_next;
    logic [SLOT_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [SLOTS-1:0]      done_reg, done_next;
    logic [SLOTS-1:0]      armed_reg, armed_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TIME_BITS-1:0]  dur_reg, dur_next;
    logic                  rep_reg, rep_next;
    logic                  res_valid_reg, res_valid_next;
    logic [EV_W-1:0]       res_ev_reg, res_ev_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic                  res_last_reg, res_last_next;

    // Memory ports
    logic                  dl_we;
    logic [SLOT_W-1:0]     dl_waddr;
    logic [TIME_BITS-1:0]  dl_rdata;
    logic                  per_we;
    logic [TIME_BITS:0]    per_rdata;

    logic [TIME_BITS-1:0]  add_a;
    logic [TIME_BITS-1:0]  add_sum;
    logic [SLOT_W-1:0]     find_idx;
    logic [SLOT_W-1:0]     cancel_idx;
    logic                  cancel_hit;
    logic                  cand;
    logic                  accept;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign find_idx = scan_cnt_reg[SLOT_W-1:0];

    assign cancel_idx = SLOT_W'(slot_id);
    assign cancel_hit = (32'(slot_id) < 32'(SLOTS));

    // Shared adder: new deadline from period on re-arm, from duration on start
    assign add_a   = (state_reg == S_REARM) ? per_rdata[TIME_BITS-1:0] : dur_reg;
    assign add_sum = add_a + now_reg;

    // Candidate test on the entry whose deadline just came out of memory
    assign cand = cmp_valid_reg && armed_reg[cmp_idx_reg] && !done_reg[cmp_idx_reg]
               && (dl_rdata <= now_reg)
               && (!pick_found_reg || (dl_rdata < pick_dl_reg));

    vtm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (add_sum),
        .raddr (find_idx),
        .rdata (dl_rdata)
    );

    vtm_ram #(
        .WIDTH (TIME_BITS + 1),
        .DEPTH (SLOTS)
    ) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (find_idx),
        .wdata ({rep_reg, dur_reg}),
        .raddr (pick_idx_reg),
        .rdata (per_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        pick_idx_next   = pick_idx_reg;
        pick_dl_next    = pick_dl_reg;
        pick_found_next = pick_found_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_idx_next   = pend_idx_reg;
        done_next       = done_reg;
        armed_next      = armed_reg;
        now_next        = now_reg;
        dur_next        = dur_reg;
        rep_next        = rep_reg;
        res_valid_next  = 1'b0;
        res_ev_next     = res_ev_reg;
        res_id_next     = res_id_reg;
        res_last_next   = res_last_reg;
        dl_we           = 1'b0;
        dl_waddr        = pick_idx_reg;
        per_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_TICK:
                        begin
                            now_next        = now_reg + TIME_BITS'(1);
                            done_next       = '0;
                            fire_cnt_next   = '0;
                            scan_cnt_next   = '0;
                            cmp_valid_next  = 1'b0;
                            pick_found_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        KIND_START:
                        begin
                            dur_next      = TIME_BITS'(duration);
                            rep_next      = repeat_req;
                            scan_cnt_next = '0;
                            state_next    = S_FIND;
                        end
                        KIND_CANCEL:
                        begin
                            if (cancel_hit)
                            begin
                                armed_next[cancel_idx] = 1'b0;
                            end
                            res_valid_next = 1'b1;
                            res_ev_next    = EV_CANCELLED;
                            res_id_next    = slot_id;
                            res_last_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk the armed flags for the lowest free slot
            S_FIND:
            begin
                if (!armed_reg[find_idx])
                begin
                    armed_next[find_idx] = 1'b1;
                    dl_we          = 1'b1;
                    dl_waddr       = find_idx;
                    per_we         = 1'b1;
                    res_valid_next = 1'b1;
                    res_ev_next    = EV_STARTED;
                    res_id_next    = ID_W'(find_idx);
                    res_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (scan_cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    res_valid_next = 1'b1;
                    res_ev_next    = EV_FULL;
                    res_id_next    = '0;
                    res_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end

            // Stream deadlines through the compare, keep the earliest due one
            S_SCAN:
            begin
                if (cand)
                begin
                    pick_found_next = 1'b1;
                    pick_idx_next   = cmp_idx_reg;
                    pick_dl_next    = dl_rdata;
                end
                if (scan_cnt_reg == CNT_W'(SLOTS))
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_FIRE;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = find_idx;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
            end

            // Mark the pick, or close the tick
            S_FIRE:
            begin
                if (pick_found_reg)
                begin
                    done_next[pick_idx_reg] = 1'b1;
                    state_next = S_REARM;
                end
                else
                begin
                    if (fire_cnt_reg != '0)
                    begin
                        res_valid_next = 1'b1;
                        res_ev_next    = EV_FIRED;
                        res_id_next    = ID_W'(pend_idx_reg);
                        res_last_next  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            // Re-arm or free the pick, release the previous fire
            S_REARM:
            begin
                if (per_rdata[TIME_BITS])
                begin
                    dl_we = 1'b1;
                end
                else
                begin
                    armed_next[pick_idx_reg] = 1'b0;
                end
                if (fire_cnt_reg != '0)
                begin
                    res_valid_next = 1'b1;
                    res_ev_next    = EV_FIRED;
                    res_id_next    = ID_W'(pend_idx_reg);
                    res_last_next  = 1'b0;
                end
                pend_idx_next = pick_idx_reg;
                fire_cnt_next = fire_cnt_reg + FIRE_W'(1);
                if (fire_cnt_reg == FIRE_W'(MAX_FIRE - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_cnt_next   = '0;
                    cmp_valid_next  = 1'b0;
                    pick_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            // Hand out the final fire of a full tick
            S_LAST:
            begin
                res_valid_next = 1'b1;
                res_ev_next    = EV_FIRED;
                res_id_next    = ID_W'(pend_idx_reg);
                res_last_next  = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            pick_found_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            done_reg       <= '0;
            armed_reg      <= '0;
            now_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            pick_found_reg <= pick_found_next;
            fire_cnt_reg   <= fire_cnt_next;
            done_reg       <= done_next;
            armed_reg      <= armed_next;
            now_reg        <= now_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        pick_idx_reg <= pick_idx_next;
        pick_dl_reg  <= pick_dl_next;
        pend_idx_reg <= pend_idx_next;
        dur_reg      <= dur_next;
        rep_reg      <= rep_next;
        res_ev_reg   <= res_ev_next;
        res_id_reg   <= res_id_next;
        res_last_reg <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign event_res    = res_ev_reg;
    assign event_slot   = res_id_reg;
    assign last         = res_last_reg;

    // Checks
    a_fire_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(MAX_FIRE))
        else $error("fire count past limit");

    a_rearm_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REARM) |-> armed_reg[pick_idx_reg])
        else $error("re-arm of a slot that is not armed");

    a_fired_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_next && (res_ev_next == EV_FIRED)) |->
        ((state_reg == S_FIRE) || (state_reg == S_REARM) || (state_reg == S_LAST)))
        else $error("fire result outside the tick sequence");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_TICK)) |=> busy)
        else $error("tick accepted without going busy");

endmodule

// ===== rtl/vtm_ram.sv =====
module vtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/tb_virtual_timer_multiplexer_core.sv =====
module tb_virtual_timer_multiplexer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vtm_pkg::*;

    localparam int NSLOTS       = SLOTS_DEF;
    localparam int TBITS        = TIME_BITS_DEF;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4 * (NSLOTS + 3);
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        event_t          ev;
        logic [ID_W-1:0] id;
        logic            last;
    } timer_event_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    kind_t             kind       = KIND_TICK;
    logic [DUR_W-1:0]  duration   = '0;
    logic              repeat_req = 1'b0;
    logic [ID_W-1:0]   slot_id    = '0;
    logic              busy;
    logic              result_valid;
    logic [EV_W-1:0]   event_res;
    logic [ID_W-1:0]   event_slot;
    logic              last;

    // Shadow copy of the timer slots
    logic [TBITS-1:0]  now_us = '0;
    bit   [NSLOTS-1:0] armed = '0;
    bit   [NSLOTS-1:0] repeating = '0;
    logic [TBITS-1:0]  period [NSLOTS];
    logic [TBITS-1:0]  deadline [NSLOTS];

    timer_event_t      pending_events [$];
    int                errors = 0;
    int                idle_pct = 0;
    int                stall_cycles = 0;

    virtual_timer_multiplexer_core #(
        .SLOTS     (NSLOTS),
        .TIME_BITS (TBITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .duration     (duration),
        .repeat_req   (repeat_req),
        .slot_id      (slot_id),
        .result_valid (result_valid),
        .event_res    (event_res),
        .event_slot   (event_slot),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the shadow slots by one item and queue the events it should produce
    task automatic predict_timer_events(input kind_t k, input logic [DUR_W-1:0] dur,
                                        input logic rep, input logic [ID_W-1:0] sid);
        timer_event_t      evs [$];
        bit [NSLOTS-1:0]   fired;
        int                pick;
        int                free_slot;
        fired = '0;
        case (k)
            KIND_TICK:
            begin
                now_us = now_us + 1'b1;
                // Fire due slots, earliest deadline first, ties to the lower slot
                for (int n = 0; n < MAX_FIRE; n++)
                begin
                    pick = -1;
                    for (int s = 0; s < NSLOTS; s++)
                    begin
                        if (armed[s] && !fired[s] && deadline[s] <= now_us &&
                            (pick < 0 || deadline[s] < deadline[pick]))
                            pick = s;
                    end
                    if (pick < 0)
                        break;
                    fired[pick] = 1'b1;
                    if (repeating[pick])
                        deadline[pick] = period[pick] + now_us;
                    else
                        armed[pick] = 1'b0;
                    evs.push_back('{EV_FIRED, pick[ID_W-1:0], 1'b0});
                end
            end
            KIND_START:
            begin
                free_slot = -1;
                for (int s = 0; s < NSLOTS; s++)
                begin
                    if (!armed[s] && free_slot < 0)
                        free_slot = s;
                end
                if (free_slot < 0)
                    evs.push_back('{EV_FULL, '0, 1'b0});
                else
                begin
                    armed[free_slot]     = 1'b1;
                    repeating[free_slot] = rep;
                    period[free_slot]    = dur;
                    deadline[free_slot]  = dur + now_us;
                    evs.push_back('{EV_STARTED, free_slot[ID_W-1:0], 1'b0});
                end
            end
            KIND_CANCEL:
            begin
                if (sid < NSLOTS)
                    armed[sid] = 1'b0;
                evs.push_back('{EV_CANCELLED, sid, 1'b0});
            end
            default:
            begin
            end
        endcase
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            pending_events.push_back(evs[i]);
    endtask

    // Hand one item to the block, with an optional gap first
    task automatic send_item(input kind_t k, input logic [DUR_W-1:0] dur, input logic rep,
                             input logic [ID_W-1:0] sid);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        duration   <= dur;
        repeat_req <= rep;
        slot_id    <= sid;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_timer_events(k, dur, rep, sid);
    endtask

    // Ticks with nothing armed, and the unused kind
    task automatic test_idle_ticks();
        send_item(KIND_TICK, '0, 1'b0, '0);
        send_item(KIND_NONE, '1, 1'b1, '1);
        send_item(KIND_TICK, '0, 1'b0, '0);
    endtask

    // Zero-period repeat, deadline ordering and a wrapped deadline
    task automatic test_fire_order();
        send_item(KIND_START, '0, 1'b1, '0);
        send_item(KIND_START, 32'd3, 1'b0, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
        // All-ones duration wraps to a deadline just behind the counter
        send_item(KIND_START, '1, 1'b1, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
    endtask

    // Cancel armed slots and a free one
    task automatic test_cancel();
        send_item(KIND_CANCEL, '0, 1'b0, 3'd0);
        send_item(KIND_CANCEL, '0, 1'b0, 3'd1);
        send_item(KIND_CANCEL, '0, 1'b0, 3'd7);
    endtask

    // Fill every slot, overflow once, then fire them all in one tick
    task automatic test_full_burst();
        for (int s = 0; s < NSLOTS; s++)
            send_item(KIND_START, 32'd1, s[0], '0);
        send_item(KIND_START, 32'd5, 1'b0, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
        send_item(KIND_TICK, '0, 1'b0, '0);
    endtask

    // Mostly ticks and starts with short durations, so slots keep firing
    task automatic test_random_traffic(input int n_items);
        int               sent;
        int               roll;
        logic [DUR_W-1:0] dur;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
                dur = $urandom_range(12);
            else if (roll < 85)
                dur = $urandom_range(400);
            else if (roll < 92)
                dur = ~($urandom_range(6));
            else
                dur = $urandom();
            roll = $urandom_range(99);
            if (roll < 48)
                send_item(KIND_TICK, $urandom(), 1'($urandom_range(1)),
                          ID_W'($urandom_range(7)));
            else if (roll < 74)
                send_item(KIND_START, dur, 1'($urandom_range(1)), ID_W'($urandom_range(7)));
            else if (roll < 94)
                send_item(KIND_CANCEL, $urandom(), 1'($urandom_range(1)),
                          ID_W'($urandom_range(7)));
            else
                send_item(KIND_NONE, $urandom(), 1'($urandom_range(1)),
                          ID_W'($urandom_range(7)));
            if (roll < 94)
                sent++;
        end
    endtask

    // Compare each result with the oldest expected event
    always @(posedge clk)
    begin : check_results
        timer_event_t want;
        if (rst_n && result_valid)
        begin
            if (pending_events.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: event %0d id %0d last %0b",
                             event_res, event_slot, last);
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_res !== want.ev || event_slot !== want.id || last !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: expected event %0d id %0d last %0b, got %0d %0d %0b",
                                 want.ev, want.id, want.last, event_res, event_slot, last);
                end
            end
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_fire_order();
        test_cancel();
        test_full_burst();

        idle_pct = 27;
        test_random_traffic(45);
        idle_pct = 61;
        test_random_traffic(45);
        idle_pct = 0;
        test_random_traffic(45);

        // Hold start low and let the last results drain
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vtm_pkg.sv
rtl/vtm_ram.sv
rtl/virtual_timer_multiplexer_core.sv
tb/tb_virtual_timer_multiplexer_core.sv
